// ----- rtl/core/jsu_pkg.sv -----
package jsu_pkg;

   // Decoder phase codes; code 7 is unused and behaves as waiting
   typedef logic [2:0] phase_type;

   localparam phase_type PH_WAIT = 3'd0;
   localparam phase_type PH_STR  = 3'd1;
   localparam phase_type PH_ESC  = 3'd2;
   localparam phase_type PH_HEX1 = 3'd3;
   localparam phase_type PH_HEX2 = 3'd4;
   localparam phase_type PH_HEX3 = 3'd5;
   localparam phase_type PH_HEX4 = 3'd6;

   // Result status codes
   typedef logic [1:0] status_type;

   localparam status_type ST_NONE  = 2'd0;
   localparam status_type ST_UNIT  = 2'd1;
   localparam status_type ST_CLOSE = 2'd2;
   localparam status_type ST_ERR   = 2'd3;

   localparam int UnitWidth = 16;

   typedef logic [UnitWidth-1:0] unit_type;

   // Decoder state carried from one word to the next
   typedef struct packed {
      phase_type phase;
      unit_type  hex_value;
      logic      hex_stopped;
   } state_type;

   // Result of one word
   typedef struct packed {
      status_type status;
      unit_type   out_unit;
   } result_type;

   // Characters of interest
   localparam unit_type CH_QUOTE = 16'h0022;
   localparam unit_type CH_BSL   = 16'h005C;
   localparam unit_type CH_SLASH = 16'h002F;
   localparam unit_type CH_B     = 16'h0062;
   localparam unit_type CH_F     = 16'h0066;
   localparam unit_type CH_N     = 16'h006E;
   localparam unit_type CH_R     = 16'h0072;
   localparam unit_type CH_T     = 16'h0074;
   localparam unit_type CH_U     = 16'h0075;
   localparam unit_type CH_SPACE = 16'h0020;
   localparam unit_type CH_TAB   = 16'h0009;
   localparam unit_type CH_CR    = 16'h000D;
   localparam unit_type CH_LF    = 16'h000A;
   localparam unit_type CH_BS    = 16'h0008;
   localparam unit_type CH_FF    = 16'h000C;

endpackage

// ----- rtl/core/jsu_step.sv -----
module jsu_step import jsu_pkg::*; (
   input  state_type  cur,
   input  unit_type   code_unit,
   input  logic       end_of_text,
   output state_type  nxt,
   output result_type res
);

   logic       hex_ok;
   logic [3:0] hex_nib;

   // hex digit classification
   always_comb begin
      hex_ok  = 1'b1;
      hex_nib = 4'd0;
      if (code_unit >= 16'h0030 && code_unit <= 16'h0039) begin
         hex_nib = code_unit[3:0];
      end else if ((code_unit >= 16'h0061 && code_unit <= 16'h0066) ||
                   (code_unit >= 16'h0041 && code_unit <= 16'h0046)) begin
         hex_nib = code_unit[3:0] + 4'd9;
      end else begin
         hex_ok = 1'b0;
      end
   end

   always_comb begin
      nxt          = cur;
      res.status   = ST_NONE;
      res.out_unit = '0;
      unique case (cur.phase) inside
         PH_STR: begin
            if (end_of_text) begin
               res.status = ST_ERR;
               nxt.phase  = PH_WAIT;
            end else if (code_unit == CH_QUOTE) begin
               res.status = ST_CLOSE;
               nxt.phase  = PH_WAIT;
            end else if (code_unit == CH_BSL) begin
               nxt.phase = PH_ESC;
            end else begin
               res.status   = ST_UNIT;
               res.out_unit = code_unit;
            end
         end
         PH_ESC: begin
            nxt.phase = PH_STR;
            if (end_of_text) begin
               res.status = ST_ERR;
               nxt.phase  = PH_WAIT;
            end else begin
               res.status = ST_UNIT;
               case (code_unit)
                  CH_QUOTE: res.out_unit = CH_QUOTE;
                  CH_BSL:   res.out_unit = CH_BSL;
                  CH_SLASH: res.out_unit = CH_SLASH;
                  CH_B:     res.out_unit = CH_BS;
                  CH_F:     res.out_unit = CH_FF;
                  CH_N:     res.out_unit = CH_LF;
                  CH_R:     res.out_unit = CH_CR;
                  CH_T:     res.out_unit = CH_TAB;
                  CH_U: begin
                     res.status      = ST_NONE;
                     nxt.hex_value   = '0;
                     nxt.hex_stopped = 1'b0;
                     nxt.phase       = PH_HEX1;
                  end
                  default: begin
                     res.status = ST_ERR;
                     nxt.phase  = PH_WAIT;
                  end
               endcase
            end
         end
         PH_HEX1, PH_HEX2, PH_HEX3, PH_HEX4: begin
            if (end_of_text) begin
               res.status = ST_ERR;
               nxt.phase  = PH_WAIT;
            end else begin
               // first non-hex unit freezes the value
               if (!cur.hex_stopped) begin
                  if (hex_ok) begin
                     nxt.hex_value = {cur.hex_value[UnitWidth-5:0], hex_nib};
                  end else begin
                     nxt.hex_stopped = 1'b1;
                  end
               end
               if (cur.phase == PH_HEX4) begin
                  res.status   = ST_UNIT;
                  res.out_unit = nxt.hex_value;
                  nxt.phase    = PH_STR;
               end else begin
                  nxt.phase = cur.phase + 3'd1;
               end
            end
         end
         default: begin
            // waiting, also unused phase code
            nxt.phase = PH_WAIT;
            if (!end_of_text) begin
               if (code_unit == CH_QUOTE) begin
                  nxt.phase = PH_STR;
               end else if (code_unit == CH_SPACE || code_unit == CH_TAB ||
                            code_unit == CH_CR || code_unit == CH_LF) begin
                  res.status = ST_NONE;
               end else begin
                  res.status = ST_ERR;
               end
            end
         end
      endcase
   end

endmodule

// ----- rtl/core/json_string_unescape_core.sv -----
// Channel   Direction  Ports                                  Word
// req       in         req_valid, req_stall (out)             code_unit, end_of_text
// rsp       out        rsp_valid, rsp_stall (in)              status, out_unit
//
// Two registers: an input register and a result register, with the
// decode step between them. One word in and one word out per cycle when
// the result side does not stall; rsp_valid rises once the word has
// passed the input register and been loaded into the result register.
// Synchronous reset empties both registers and returns the
// decoder to waiting for an opening quote. A stall on rsp holds the
// result and then backs up into the input register, so req_stall rises
// only once both registers are full.
module json_string_unescape_core import jsu_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [15:0]      req_code_unit,
   input  logic             req_end_of_text,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [1:0]       rsp_status,
   output logic [15:0]      rsp_out_unit
);

   // input register
   logic       in_valid_ff;
   unit_type   in_unit_ff;
   logic       in_eot_ff;

   // decoder state and result register
   state_type  state_ff;
   state_type  state_in;
   result_type res_in;
   logic       out_valid_ff;
   result_type out_ff;

   // result register free or being emptied this cycle
   logic       advance;
   logic       step_go;

   assign advance   = !out_valid_ff || !rsp_stall;
   assign step_go   = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;

   jsu_step u_step (
      .cur         (state_ff),
      .code_unit   (in_unit_ff),
      .end_of_text (in_eot_ff),
      .nxt         (state_in),
      .res         (res_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '{phase: PH_WAIT, hex_value: '0, hex_stopped: 1'b0};
      end else begin
         // input register loads whenever it is not held
         if (!req_stall) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            out_valid_ff <= in_valid_ff;
         end
         // state moves only with a word that reaches the result register
         if (step_go) begin
            state_ff <= state_in;
         end
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         in_unit_ff <= req_code_unit;
         in_eot_ff  <= req_end_of_text;
      end
      if (step_go) begin
         out_ff <= res_in;
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_status   = out_ff.status;
   assign rsp_out_unit = out_ff.out_unit;

   // assertions

   // decoded unit is zero unless a unit is emitted
   a_unit_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_UNIT) |-> (rsp_out_unit == '0))
      else $error("non-zero unit with status other than unit");

   // after a close or an error the decoder is waiting again
   a_back_to_wait: assert property (@(posedge clock) disable iff (reset)
      ($past(step_go) && (out_ff.status == ST_CLOSE || out_ff.status == ST_ERR))
      |-> (state_ff.phase == PH_WAIT))
      else $error("decoder not waiting after close or error");

   // a word leaving the input register shows up as a result next cycle
   a_step_out: assert property (@(posedge clock) disable iff (reset)
      step_go |=> out_valid_ff)
      else $error("result word lost");

   // reset leaves nothing in flight
   a_reset_clear: assert property (@(posedge clock)
      reset |=> (!out_valid_ff && !in_valid_ff && state_ff.phase == PH_WAIT))
      else $error("state not cleared by reset");

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps

module tb import jsu_pkg::*; ();

   // ------------------------------------------------------------------
   // Scoreboard: carries its own copy of the decoder state, works out the
   // result of each accepted word and holds it until the block answers.
   // ------------------------------------------------------------------
   class unescape_checker;
      phase_type    phase;
      unit_type     hex_acc;
      logic         hex_halted;
      result_type   pending[$];
      int           errors;
      int           words_noted;
      int           seen[4];

      function new();
         phase       = PH_WAIT;
         hex_acc     = '0;
         hex_halted  = 1'b0;
         errors      = 0;
         words_noted = 0;
         foreach (seen[i]) seen[i] = 0;
      endfunction

      // hex digit value in [3:0]; bit 4 set for a non-hex unit
      function logic [4:0] hex_digit(unit_type cu);
         if (cu >= 16'h0030 && cu <= 16'h0039) return {1'b0, cu[3:0]};
         if ((cu >= 16'h0061 && cu <= 16'h0066) || (cu >= 16'h0041 && cu <= 16'h0046))
            return {1'b0, cu[3:0] + 4'd9};
         return 5'h10;
      endfunction

      // one accepted word in, one expected result out
      function void note_word(unit_type cu, logic eot);
         result_type  res;
         logic [4:0]  dig;
         res.status   = ST_NONE;
         res.out_unit = '0;
         words_noted++;
         case (phase)
            PH_STR: begin
               if (eot) begin
                  res.status = ST_ERR;
                  phase      = PH_WAIT;
               end else if (cu == CH_QUOTE) begin
                  res.status = ST_CLOSE;
                  phase      = PH_WAIT;
               end else if (cu == CH_BSL) begin
                  phase = PH_ESC;
               end else begin
                  res.status   = ST_UNIT;
                  res.out_unit = cu;
               end
            end
            PH_ESC: begin
               if (eot) begin
                  res.status = ST_ERR;
                  phase      = PH_WAIT;
               end else begin
                  phase      = PH_STR;
                  res.status = ST_UNIT;
                  case (cu)
                     CH_QUOTE: res.out_unit = CH_QUOTE;
                     CH_BSL:   res.out_unit = CH_BSL;
                     CH_SLASH: res.out_unit = CH_SLASH;
                     CH_B:     res.out_unit = CH_BS;
                     CH_F:     res.out_unit = CH_FF;
                     CH_N:     res.out_unit = CH_LF;
                     CH_R:     res.out_unit = CH_CR;
                     CH_T:     res.out_unit = CH_TAB;
                     CH_U: begin
                        res.status = ST_NONE;
                        hex_acc    = '0;
                        hex_halted = 1'b0;
                        phase      = PH_HEX1;
                     end
                     default: begin
                        res.status = ST_ERR;
                        phase      = PH_WAIT;
                     end
                  endcase
               end
            end
            PH_HEX1, PH_HEX2, PH_HEX3, PH_HEX4: begin
               if (eot) begin
                  res.status = ST_ERR;
                  phase      = PH_WAIT;
               end else begin
                  dig = hex_digit(cu);
                  // first non-hex unit freezes the value for the rest
                  if (!hex_halted) begin
                     if (!dig[4]) hex_acc = {hex_acc[11:0], dig[3:0]};
                     else         hex_halted = 1'b1;
                  end
                  if (phase == PH_HEX4) begin
                     res.status   = ST_UNIT;
                     res.out_unit = hex_acc;
                     phase        = PH_STR;
                  end else begin
                     phase = phase + 3'd1;
                  end
               end
            end
            default: begin
               // waiting; the unused code behaves the same
               phase = PH_WAIT;
               if (!eot) begin
                  if (cu == CH_QUOTE) phase = PH_STR;
                  else if (!(cu == CH_SPACE || cu == CH_TAB || cu == CH_CR || cu == CH_LF))
                     res.status = ST_ERR;
               end
            end
         endcase
         pending.insert(pending.size(), res);
      endfunction

      function void check_result(status_type st, unit_type ou, longint unsigned now);
         result_type want;
         if (pending.size() == 0) begin
            errors++;
            $display("%0t: unexpected result status %0d unit %h", now, st, ou);
            return;
         end
         want = pending.pop_front();
         seen[st]++;
         if (st !== want.status) begin
            errors++;
            $display("%0t: status mismatch, expected %0d, actual %0d",
                     now, want.status, st);
         end
         if (ou !== want.out_unit) begin
            errors++;
            $display("%0t: out_unit mismatch, expected %h, actual %h",
                     now, want.out_unit, ou);
         end
      endfunction
   endclass

   localparam int RandomWords = 1600;
   localparam int CalmTail    = 150;   // last words run with no idling on either side

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [15:0] req_code_unit;
   logic        req_end_of_text;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [1:0]  rsp_status;
   logic [15:0] rsp_out_unit;

   unescape_checker sb;

   int  words_sent;
   int  send_gap_pct;
   int  stall_pct;
   bit  calm;

   unit_type esc_units[8] = '{CH_QUOTE, CH_BSL, CH_SLASH, CH_B, CH_F, CH_N, CH_R, CH_T};

   json_string_unescape_core uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_code_unit   (req_code_unit),
      .req_end_of_text (req_end_of_text),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_out_unit    (rsp_out_unit)
   );

   // 8 ns clock
   initial clock = 1'b0;
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Both handshakes are sampled at the rising edge, before the block's own
   // registers move, so the values seen are the ones that were offered.
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall)
         sb.note_word(req_code_unit, req_end_of_text);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_result(rsp_status, rsp_out_unit, $time);
   end

   // Result side: stalls come in bursts, at a rate the stimulus loop
   // varies; none at all during the calm tail.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (!calm && $urandom_range(0, 99) < stall_pct) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 6)) @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Offer one word and hold it until taken. Entered and left at a falling
   // edge, so valid is assigned once per step and never dropped between
   // back-to-back words.
   task automatic send_word(input unit_type cu, input logic eot);
      if (!calm && $urandom_range(0, 99) < send_gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_code_unit   <= cu;
      req_end_of_text <= eot;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      words_sent++;
   endtask

   // Sender holds off until every outstanding result has come back
   task automatic drain();
      req_valid <= 1'b0;
      @(negedge clock);
      while (sb.pending.size() != 0) @(negedge clock);
   endtask

   function automatic unit_type space_unit();
      case ($urandom_range(0, 3))
         0:       return CH_SPACE;
         1:       return CH_TAB;
         2:       return CH_CR;
         default: return CH_LF;
      endcase
   endfunction

   // Plain string content: half the time printable, otherwise any 16-bit value
   function automatic unit_type plain_unit();
      unit_type cu;
      do begin
         if ($urandom_range(0, 1)) cu = unit_type'($urandom_range(16'h20, 16'h7E));
         else                      cu = unit_type'($urandom);
      end while (cu == CH_QUOTE || cu == CH_BSL);
      return cu;
   endfunction

   // Hex position: digits of either case, now and then a unit that stops it
   function automatic unit_type hex_unit();
      case ($urandom_range(0, 9))
         0:       return unit_type'($urandom);
         1, 2:    return unit_type'(16'h0061 + $urandom_range(0, 5));
         3, 4:    return unit_type'(16'h0041 + $urandom_range(0, 5));
         default: return unit_type'(16'h0030 + $urandom_range(0, 9));
      endcase
   endfunction

   function automatic unit_type bad_escape_unit();
      unit_type cu;
      do cu = unit_type'($urandom);
      while (cu inside {CH_QUOTE, CH_BSL, CH_SLASH, CH_B, CH_F, CH_N, CH_R, CH_T, CH_U});
      return cu;
   endfunction

   // A string literal: mostly well formed, sometimes cut short by end of
   // text or by a bad escape
   task automatic send_string();
      int n_tok;
      int pick;
      repeat ($urandom_range(0, 2)) send_word(space_unit(), 1'b0);
      send_word(CH_QUOTE, 1'b0);
      n_tok = $urandom_range(0, 8);
      for (int k = 0; k < n_tok; k++) begin
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            send_word(plain_unit(), 1'b0);
         end else if (pick < 75) begin
            send_word(CH_BSL, 1'b0);
            send_word(esc_units[$urandom_range(0, 7)], 1'b0);
         end else if (pick < 95) begin
            send_word(CH_BSL, 1'b0);
            send_word(CH_U, 1'b0);
            repeat (4) send_word(hex_unit(), 1'b0);
         end else begin
            send_word(CH_BSL, 1'b0);
            send_word(bad_escape_unit(), 1'b0);
            return;
         end
      end
      case ($urandom_range(0, 19))
         0: send_word(unit_type'($urandom), 1'b1);
         1: begin
            send_word(CH_BSL, 1'b0);
            send_word(unit_type'($urandom), 1'b1);
         end
         2: begin
            send_word(CH_BSL, 1'b0);
            send_word(CH_U, 1'b0);
            repeat ($urandom_range(0, 3)) send_word(hex_unit(), 1'b0);
            send_word(unit_type'($urandom), 1'b1);
         end
         default: send_word(CH_QUOTE, 1'b0);
      endcase
   endtask

   int  target;
   bit  drained;

   initial begin
      sb              = new();
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_code_unit   = '0;
      req_end_of_text = 1'b0;
      words_sent      = 0;
      send_gap_pct    = 0;
      stall_pct       = 0;
      calm            = 1'b0;
      drained         = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: whitespace, end of text and a stray unit while waiting,
      // extreme plain units, every simple escape, a mixed-case \u and an
      // unknown escape
      send_word(CH_SPACE, 1'b0);
      send_word(CH_TAB, 1'b0);
      send_word(CH_CR, 1'b0);
      send_word(CH_LF, 1'b0);
      send_word(16'hFFFF, 1'b1);
      send_word(16'h0078, 1'b0);
      send_word(CH_QUOTE, 1'b0);
      send_word(16'hFFFF, 1'b0);
      send_word(16'h0000, 1'b0);
      foreach (esc_units[i]) begin
         send_word(CH_BSL, 1'b0);
         send_word(esc_units[i], 1'b0);
      end
      send_word(CH_BSL, 1'b0);
      send_word(CH_U, 1'b0);
      send_word(16'h0046, 1'b0);
      send_word(16'h0061, 1'b0);
      send_word(16'h0030, 1'b0);
      send_word(16'h0039, 1'b0);
      send_word(CH_BSL, 1'b0);
      send_word(16'h0078, 1'b0);
      drain();

      // Random: strings with random content plus bursts of raw noise;
      // idling rates on both sides shift now and then, zero included
      target = words_sent + RandomWords;
      send_gap_pct = 15;
      stall_pct    = 15;
      while (words_sent < target) begin
         if ($urandom_range(0, 7) == 0) begin
            send_gap_pct = $urandom_range(0, 2) * 20;
            stall_pct    = $urandom_range(0, 2) * 20;
         end
         calm = (words_sent > target - CalmTail);
         if (!drained && words_sent > target - RandomWords / 2) begin
            drain();
            drained = 1'b1;
         end
         if ($urandom_range(0, 99) < 85)
            send_string();
         else
            repeat ($urandom_range(1, 6))
               send_word(unit_type'($urandom), $urandom_range(0, 5) == 0);
      end
      req_valid <= 1'b0;

      // Let everything outstanding come back, then keep watching to catch
      // anything extra
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("%0d words accepted; results: %0d silent, %0d units, %0d closes, %0d errors",
               sb.words_noted, sb.seen[ST_NONE], sb.seen[ST_UNIT], sb.seen[ST_CLOSE],
               sb.seen[ST_ERR]);
      if (sb.errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Watchdog, far beyond the slowest legal run
   initial begin
      #5000000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/core/jsu_pkg.sv
rtl/core/jsu_step.sv
rtl/core/json_string_unescape_core.sv
tb/sv/tb.sv
